// ===== hw/rtl/ppsd_pkg.sv =====
package ppsd_pkg;

    // datapath widths
    localparam int ACC_W      = 68;
    localparam int MUL_W      = 18;
    localparam int LOAD_W     = 48;
    localparam int DIVIDEND_W = 33;
    localparam int DIVISOR_W  = 64;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd5;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic [47:0] INT48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] INT48_MIN = 48'h8000_0000_0000;
    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_LOAD,
        MAC_ADD,
        MAC_SHR16
    } mac_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32
    } mac_sh_t;

    typedef struct packed {
        mac_op_t           op;
        mac_sh_t           sh;
        logic [MUL_W-1:0]  a;
        logic [MUL_W-1:0]  b;
        logic [LOAD_W-1:0] load;
    } mac_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMA_LD,
        ST_EMA_MUL,
        ST_INT_LD,
        ST_INT_M0,
        ST_INT_M1,
        ST_INT_M2,
        ST_INT_WAIT,
        ST_INT_SAT,
        ST_DIV_WAIT,
        ST_D_M0,
        ST_D_M1,
        ST_D_M2,
        ST_D_SHR,
        ST_P_MUL,
        ST_I_M0,
        ST_I_M1,
        ST_I_M2,
        ST_DRV_WAIT,
        ST_FIN
    } state_t;

endpackage

// ===== hw/rtl/ppsd_div.sv =====
module ppsd_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ppsd_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [ppsd_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                busy,
    output logic [ppsd_pkg::DIVIDEND_W-1:0]     quotient
);

    localparam int DvdW = ppsd_pkg::DIVIDEND_W;
    localparam int DvsW = ppsd_pkg::DIVISOR_W;
    localparam int CntW = ppsd_pkg::DIV_CNT_W;

    logic            busy_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DvdW-1:0] rem_reg;
    logic [DvdW-1:0] quo_reg;
    logic [DvsW-1:0] dvs_reg;

    logic [DvdW:0]   rem_shift;
    logic            fits;
    logic [DvdW:0]   rem_sub;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DvdW-1]};
        fits      = DvsW'(rem_shift) >= dvs_reg;
        rem_sub   = rem_shift - dvs_reg[DvdW:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(DvdW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[DvdW-1:0] : rem_shift[DvdW-1:0];
            quo_reg <= {quo_reg[DvdW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/ppsd_mac.sv =====
module ppsd_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  ppsd_pkg::mac_cmd_t                      cmd,
    output logic signed [ppsd_pkg::ACC_W-1:0]       acc
);

    localparam int AccW  = ppsd_pkg::ACC_W;
    localparam int ProdW = 2 * ppsd_pkg::MUL_W;

    ppsd_pkg::mac_op_t                  op_reg;
    ppsd_pkg::mac_sh_t                  sh_reg;
    logic signed [ProdW-1:0]            prod_reg;
    logic [ppsd_pkg::LOAD_W-1:0]        load_reg;
    logic signed [AccW-1:0]             acc_reg;

    logic signed [AccW-1:0]             prod_ext;
    logic signed [AccW-1:0]             prod_shl;
    logic signed [AccW-1:0]             acc_next;

    // stage 1: multiply, command rides along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= ppsd_pkg::MAC_NOP;
        end else begin
            op_reg <= cmd.op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(cmd.a) * $signed(cmd.b);
        sh_reg   <= cmd.sh;
        load_reg <= cmd.load;
    end

    // stage 2: shifted accumulate
    always_comb begin
        prod_ext = AccW'(prod_reg);
        unique case (sh_reg)
            ppsd_pkg::SH_0:  prod_shl = prod_ext;
            ppsd_pkg::SH_16: prod_shl = prod_ext <<< 16;
            ppsd_pkg::SH_32: prod_shl = prod_ext <<< 32;
            default:         prod_shl = prod_ext;
        endcase
    end

    always_comb begin
        unique case (op_reg)
            ppsd_pkg::MAC_NOP:   acc_next = acc_reg;
            ppsd_pkg::MAC_LOAD:  acc_next = AccW'($signed(load_reg));
            ppsd_pkg::MAC_ADD:   acc_next = acc_reg + prod_shl;
            ppsd_pkg::MAC_SHR16: acc_next = acc_reg >>> 16;
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/pid_pressure_step_deadband.sv =====
// sequence: prep, ema, integral update, divider wait, derivative, proportional and integral terms, then the result load
// one item at a time: s_ready is high only in ST_IDLE; the 33-step restoring divider for the
//   derivative bounds the pace, the shared 18x18 mac runs beside it
// a finished result waits in the output register while the next beat is taken
// reset: synchronous active-low aresetn clears control, controller state and config registers;
//   working and result data registers are not reset (ema alpha resets to one)
module pid_pressure_step_deadband (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // configuration write port
    input  logic                                    cfg_we,
    input  logic [ppsd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ppsd_pkg::CFG_DATA_W-1:0]         cfg_data,

    // sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [15:0]                      s_pressure,
    input  logic [63:0]                             s_timestamp_us,

    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [31:0]                      m_drive,
    output logic                                    m_in_deadband,
    output logic                                    m_zero_interval,
    output logic signed [15:0]                      m_filtered_pressure
);

    localparam int AccW = ppsd_pkg::ACC_W;
    localparam int DvdW = ppsd_pkg::DIVIDEND_W;

    // configuration registers
    logic signed [15:0] target_reg;
    logic [15:0]        deadband_reg;
    logic [15:0]        gain_p_reg;
    logic [15:0]        gain_i_reg;
    logic [15:0]        gain_d_reg;
    logic [16:0]        alpha_reg;

    // controller state carried from sample to sample
    logic [63:0]        last_time_reg;
    logic signed [47:0] integ_reg;
    logic signed [16:0] last_err_reg;
    logic signed [15:0] smooth_reg;

    // per-sample working registers
    logic signed [15:0] p_reg;
    logic [63:0]        t_reg;
    logic signed [16:0] e_reg;
    logic signed [17:0] diff_reg;
    logic signed [16:0] ps_diff_reg;
    logic [16:0]        alpha_c_reg;
    logic [63:0]        interval_reg;
    logic [47:0]        iv_reg;
    logic               ivz_reg;
    logic               db_reg;
    logic signed [15:0] f_reg;
    logic signed [47:0] inew_reg;
    logic signed [33:0] d_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] drive_reg;
    logic               in_db_reg;
    logic               zero_iv_reg;
    logic signed [15:0] filt_reg;

    ppsd_pkg::state_t   state_reg;
    ppsd_pkg::state_t   state_next;

    // sequencer outputs
    ppsd_pkg::mac_cmd_t mac_cmd;
    logic               in_beat;
    logic               prep_en;
    logic               div_start;
    logic               f_cap;
    logic               inew_cap;
    logic               d_cap;
    logic               out_free;
    logic               out_load;

    // shared units
    logic signed [AccW-1:0] acc;
    logic                   div_busy;
    logic [DvdW-1:0]        div_q;

    // combinational datapath
    logic signed [16:0] e_w;
    logic [16:0]        mag_w;
    logic signed [17:0] diff_w;
    logic signed [16:0] ps_w;
    logic [63:0]        interval_w;
    logic [17:0]        abs_diff;
    logic [DvdW-1:0]    dividend_w;
    logic signed [47:0] inew_w;
    logic signed [31:0] drive_w;
    logic signed [33:0] d_w;

    //------------------------------------------------------------------
    // configuration writes; unknown indexes fall through
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            deadband_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            alpha_reg    <= ppsd_pkg::ALPHA_ONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ppsd_pkg::REG_TARGET:   target_reg   <= $signed(cfg_data[15:0]);
                ppsd_pkg::REG_DEADBAND: deadband_reg <= cfg_data[15:0];
                ppsd_pkg::REG_GAIN_P:   gain_p_reg   <= cfg_data[15:0];
                ppsd_pkg::REG_GAIN_I:   gain_i_reg   <= cfg_data[15:0];
                ppsd_pkg::REG_GAIN_D:   gain_d_reg   <= cfg_data[15:0];
                ppsd_pkg::REG_ALPHA:    alpha_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // front-end arithmetic, registered in the prep cycle
    //------------------------------------------------------------------
    always_comb begin
        // error = target minus raw sample, 17 bits signed
        e_w        = {target_reg[15], target_reg} - {p_reg[15], p_reg};
        mag_w      = e_w[16] ? 17'(-e_w) : e_w;
        diff_w     = {e_w[16], e_w} - {last_err_reg[16], last_err_reg};
        // ema written as s + alpha*(p - s) / 2^16
        ps_w       = {p_reg[15], p_reg} - {smooth_reg[15], smooth_reg};
        interval_w = t_reg - last_time_reg;
    end

    // derivative numerator |diff| << 16
    always_comb begin
        abs_diff   = diff_reg[17] ? 18'(-diff_reg) : diff_reg;
        dividend_w = {abs_diff[16:0], 16'h0000};
    end

    // integral clamp to 48 bits
    always_comb begin
        if (acc[AccW-1:47] == {(AccW-47){acc[47]}}) begin
            inew_w = acc[47:0];
        end else if (acc[AccW-1]) begin
            inew_w = ppsd_pkg::INT48_MIN;
        end else begin
            inew_w = ppsd_pkg::INT48_MAX;
        end
    end

    // drive: floor >> 8 then clamp to 32 bits
    always_comb begin
        if (acc[AccW-1:39] == {(AccW-39){acc[39]}}) begin
            drive_w = acc[39:8];
        end else if (acc[AccW-1]) begin
            drive_w = ppsd_pkg::INT32_MIN;
        end else begin
            drive_w = ppsd_pkg::INT32_MAX;
        end
    end

    // signed derivative, truncated toward zero; forced to 0 on zero interval
    always_comb begin
        if (ivz_reg) begin
            d_w = '0;
        end else if (diff_reg[17]) begin
            d_w = -$signed({1'b0, div_q});
        end else begin
            d_w = $signed({1'b0, div_q});
        end
    end

    //------------------------------------------------------------------
    // working registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            p_reg <= s_pressure;
            t_reg <= s_timestamp_us;
        end
        if (prep_en) begin
            e_reg        <= e_w;
            diff_reg     <= diff_w;
            ps_diff_reg  <= ps_w;
            alpha_c_reg  <= (alpha_reg > ppsd_pkg::ALPHA_ONE) ? ppsd_pkg::ALPHA_ONE
                                                               : alpha_reg;
            interval_reg <= interval_w;
            // any interval of 2^48 or more saturates the integral anyway unless the error is zero
            iv_reg       <= (interval_w[63:48] != '0) ? '1 : interval_w[47:0];
            ivz_reg      <= interval_w == '0;
            db_reg       <= mag_w < {1'b0, deadband_reg};
        end
        if (f_cap) begin
            f_reg <= acc[31:16];
        end
        if (inew_cap) begin
            inew_reg <= inew_w;
        end
        if (d_cap) begin
            d_reg <= d_w;
        end
    end

    //------------------------------------------------------------------
    // state update and result register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            smooth_reg    <= '0;
        end else if (out_load) begin
            last_time_reg <= t_reg;
            if (db_reg) begin
                // inside deadband: integral cleared, filter and error kept
                integ_reg <= '0;
            end else begin
                integ_reg    <= inew_reg;
                last_err_reg <= e_reg;
                smooth_reg   <= f_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_reg   <= db_reg ? 32'sd0 : drive_w;
            in_db_reg   <= db_reg;
            zero_iv_reg <= !db_reg && ivz_reg;
            filt_reg    <= f_reg;
        end
    end

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppsd_pkg::ST_IDLE:     if (s_valid) state_next = ppsd_pkg::ST_PREP;
            ppsd_pkg::ST_PREP:     state_next = ppsd_pkg::ST_EMA_LD;
            ppsd_pkg::ST_EMA_LD:   state_next = ppsd_pkg::ST_EMA_MUL;
            ppsd_pkg::ST_EMA_MUL:  state_next = ppsd_pkg::ST_INT_LD;
            ppsd_pkg::ST_INT_LD:   state_next = ppsd_pkg::ST_INT_M0;
            ppsd_pkg::ST_INT_M0:   state_next = ppsd_pkg::ST_INT_M1;
            ppsd_pkg::ST_INT_M1:   state_next = ppsd_pkg::ST_INT_M2;
            ppsd_pkg::ST_INT_M2:   state_next = ppsd_pkg::ST_INT_WAIT;
            ppsd_pkg::ST_INT_WAIT: state_next = ppsd_pkg::ST_INT_SAT;
            ppsd_pkg::ST_INT_SAT:  state_next = ppsd_pkg::ST_DIV_WAIT;
            ppsd_pkg::ST_DIV_WAIT: if (!div_busy) state_next = ppsd_pkg::ST_D_M0;
            ppsd_pkg::ST_D_M0:     state_next = ppsd_pkg::ST_D_M1;
            ppsd_pkg::ST_D_M1:     state_next = ppsd_pkg::ST_D_M2;
            ppsd_pkg::ST_D_M2:     state_next = ppsd_pkg::ST_D_SHR;
            ppsd_pkg::ST_D_SHR:    state_next = ppsd_pkg::ST_P_MUL;
            ppsd_pkg::ST_P_MUL:    state_next = ppsd_pkg::ST_I_M0;
            ppsd_pkg::ST_I_M0:     state_next = ppsd_pkg::ST_I_M1;
            ppsd_pkg::ST_I_M1:     state_next = ppsd_pkg::ST_I_M2;
            ppsd_pkg::ST_I_M2:     state_next = ppsd_pkg::ST_DRV_WAIT;
            ppsd_pkg::ST_DRV_WAIT: state_next = ppsd_pkg::ST_FIN;
            ppsd_pkg::ST_FIN:      if (out_free) state_next = ppsd_pkg::ST_IDLE;
            default:               state_next = ppsd_pkg::ST_IDLE;
        endcase
    end

    // mac commands reach acc through the multiply register, then the accumulator register
    always_comb begin
        s_ready      = 1'b0;
        prep_en      = 1'b0;
        div_start    = 1'b0;
        f_cap        = 1'b0;
        inew_cap     = 1'b0;
        d_cap        = 1'b0;
        out_load     = 1'b0;
        mac_cmd.op   = ppsd_pkg::MAC_NOP;
        mac_cmd.sh   = ppsd_pkg::SH_0;
        mac_cmd.a    = '0;
        mac_cmd.b    = '0;
        mac_cmd.load = '0;
        unique case (state_reg)
            ppsd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            ppsd_pkg::ST_PREP: begin
                prep_en = 1'b1;
            end
            ppsd_pkg::ST_EMA_LD: begin
                div_start    = 1'b1;
                mac_cmd.op   = ppsd_pkg::MAC_LOAD;
                mac_cmd.load = {{16{smooth_reg[15]}}, smooth_reg, 16'h0000};
            end
            ppsd_pkg::ST_EMA_MUL: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.a  = {1'b0, alpha_c_reg};
                mac_cmd.b  = {ps_diff_reg[16], ps_diff_reg};
            end
            ppsd_pkg::ST_INT_LD: begin
                mac_cmd.op   = ppsd_pkg::MAC_LOAD;
                mac_cmd.load = integ_reg;
            end
            ppsd_pkg::ST_INT_M0: begin
                // ema result is in acc this cycle
                f_cap      = 1'b1;
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.a  = {e_reg[16], e_reg};
                mac_cmd.b  = {2'b00, iv_reg[15:0]};
            end
            ppsd_pkg::ST_INT_M1: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_16;
                mac_cmd.a  = {e_reg[16], e_reg};
                mac_cmd.b  = {2'b00, iv_reg[31:16]};
            end
            ppsd_pkg::ST_INT_M2: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_32;
                mac_cmd.a  = {e_reg[16], e_reg};
                mac_cmd.b  = {2'b00, iv_reg[47:32]};
            end
            ppsd_pkg::ST_INT_WAIT: begin
            end
            ppsd_pkg::ST_INT_SAT: begin
                inew_cap = 1'b1;
            end
            ppsd_pkg::ST_DIV_WAIT: begin
                // clear acc for the drive sum while the divider finishes
                mac_cmd.op = ppsd_pkg::MAC_LOAD;
                d_cap      = !div_busy;
            end
            ppsd_pkg::ST_D_M0: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.a  = {2'b00, gain_d_reg};
                mac_cmd.b  = {2'b00, d_reg[15:0]};
            end
            ppsd_pkg::ST_D_M1: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_16;
                mac_cmd.a  = {2'b00, gain_d_reg};
                mac_cmd.b  = {2'b00, d_reg[31:16]};
            end
            ppsd_pkg::ST_D_M2: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_32;
                mac_cmd.a  = {2'b00, gain_d_reg};
                mac_cmd.b  = {{16{d_reg[33]}}, d_reg[33:32]};
            end
            ppsd_pkg::ST_D_SHR: begin
                // floor of the derivative term alone
                mac_cmd.op = ppsd_pkg::MAC_SHR16;
            end
            ppsd_pkg::ST_P_MUL: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.a  = {2'b00, gain_p_reg};
                mac_cmd.b  = {e_reg[16], e_reg};
            end
            ppsd_pkg::ST_I_M0: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.a  = {2'b00, gain_i_reg};
                mac_cmd.b  = {2'b00, inew_reg[15:0]};
            end
            ppsd_pkg::ST_I_M1: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_16;
                mac_cmd.a  = {2'b00, gain_i_reg};
                mac_cmd.b  = {2'b00, inew_reg[31:16]};
            end
            ppsd_pkg::ST_I_M2: begin
                mac_cmd.op = ppsd_pkg::MAC_ADD;
                mac_cmd.sh = ppsd_pkg::SH_32;
                mac_cmd.a  = {2'b00, gain_i_reg};
                mac_cmd.b  = {{2{inew_reg[47]}}, inew_reg[47:32]};
            end
            ppsd_pkg::ST_DRV_WAIT: begin
            end
            ppsd_pkg::ST_FIN: begin
                // wait here if the previous result beat is still unsent
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign in_beat = s_valid && s_ready;

    //------------------------------------------------------------------
    // shared units
    //------------------------------------------------------------------
    ppsd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .acc     (acc)
    );

    ppsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_w),
        .divisor  (interval_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    //------------------------------------------------------------------
    // ports
    //------------------------------------------------------------------
    assign m_valid             = m_valid_reg;
    assign m_drive             = drive_reg;
    assign m_in_deadband       = in_db_reg;
    assign m_zero_interval     = zero_iv_reg;
    assign m_filtered_pressure = filt_reg;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    a_db_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_deadband |-> (m_drive == 32'sd0) && !m_zero_interval)
        else $error("deadband result with nonzero drive or zero-interval flag");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input beat taken while an item is in flight");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ppsd_pkg::ST_D_M0 |-> !div_busy && $past(!div_busy))
        else $error("derivative used before divider finished");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && (state_reg == ppsd_pkg::ST_IDLE))
        else $error("result load did not raise m_valid and return to idle");

endmodule
